// ===== sv/fcpu_pkg.sv =====
// shared types, codes and saturation helpers for the camera pose block
// no dependencies
package fcpu_pkg;

  localparam int InW   = 160;
  localparam int OutW  = 264;
  localparam int VecW  = 18;
  localparam int PosW  = 32;
  localparam int ProdW = 50;
  localparam int AccW  = 53;
  localparam int RndW  = 39;

  localparam logic [3:0] OP_VIEW     = 4'd0;
  localparam logic [3:0] OP_LOAD_POS = 4'd1;
  localparam logic [3:0] OP_LOAD_ORI = 4'd2;
  localparam logic [3:0] OP_FRONT    = 4'd3;
  localparam logic [3:0] OP_BACK     = 4'd4;
  localparam logic [3:0] OP_LEFT     = 4'd5;
  localparam logic [3:0] OP_RIGHT    = 4'd6;
  localparam logic [3:0] OP_UP       = 4'd7;
  localparam logic [3:0] OP_DOWN     = 4'd8;
  localparam logic [3:0] OP_TURN_R   = 4'd9;
  localparam logic [3:0] OP_TURN_L   = 4'd10;
  localparam logic [3:0] OP_TURN_U   = 4'd11;
  localparam logic [3:0] OP_TURN_D   = 4'd12;
  localparam logic [3:0] OP_TURN_CW  = 4'd13;
  localparam logic [3:0] OP_TURN_CCW = 4'd14;

  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_COS  = 2'd1;
  localparam logic [1:0] REG_SIN  = 2'd2;

  localparam logic [1:0] V_DIR = 2'd0;
  localparam logic [1:0] V_UP  = 2'd1;
  localparam logic [1:0] V_RGT = 2'd2;

  localparam logic [2:0] A_STEP = 3'd0;
  localparam logic [2:0] A_COS  = 3'd1;
  localparam logic [2:0] A_SIN  = 3'd2;
  localparam logic [2:0] A_POS  = 3'd3;
  localparam logic [2:0] A_VEC  = 3'd4;

  localparam logic [1:0] WB_VEC   = 2'd0;
  localparam logic [1:0] WB_PADD  = 2'd1;
  localparam logic [1:0] WB_PSUB  = 2'd2;
  localparam logic [1:0] WB_TRANS = 2'd3;

  localparam logic [1:0] PH_BLEND = 2'd0;
  localparam logic [1:0] PH_CROSS = 2'd1;
  localparam logic [1:0] PH_MOVE  = 2'd2;
  localparam logic [1:0] PH_TRANS = 2'd3;

  typedef struct packed {
    logic       load_pos;
    logic       load_ori;
    logic       mul_en;
    logic       acc_en;
    logic       first;
    logic       neg;
    logic [2:0] a_src;
    logic [1:0] a_vec;
    logic [1:0] a_idx;
    logic [1:0] b_vec;
    logic [1:0] b_idx;
    logic       wb_en;
    logic [1:0] wb_mode;
    logic [1:0] wb_vec;
    logic [1:0] wb_idx;
    logic       out_load;
  } fcpu_cmd_t;

  function automatic logic signed [VecW-1:0] sat18(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd131071;
    lo = -40'sd131072;
    if (v > hi) sat18 = 18'sd131071;
    else if (v < lo) sat18 = -18'sd131072;
    else sat18 = v[VecW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) sat32 = 32'h7fffffff;
    else if (v < lo) sat32 = 32'h80000000;
    else sat32 = v[PosW-1:0];
  endfunction

endpackage

// ===== sv/fcpu_ctrl.sv =====
// sequencer: walks blend, cross, move and translation phases one product at a time
// depends on fcpu_pkg
module fcpu_ctrl import fcpu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [3:0] in_opcode,
  output logic       out_tvalid,
  input  logic       out_tready,
  output fcpu_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] t_r, t_nxt;
  logic       ov_r, ov_nxt;

  logic       accept;
  logic       last_t;
  logic [1:0] i1, i2, ph_first, ph_after;
  logic [1:0] tv, ov, cav, cbv, crv, mv;
  logic       bneg, mneg;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;

  assign i1 = (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
  assign i2 = (i_r == 2'd0) ? 2'd2 : i_r - 2'd1;

  always_comb begin
    case (in_opcode)
      OP_LOAD_ORI: ph_first = PH_CROSS;
      OP_FRONT, OP_BACK, OP_LEFT, OP_RIGHT, OP_UP, OP_DOWN: ph_first = PH_MOVE;
      OP_TURN_R, OP_TURN_L, OP_TURN_U, OP_TURN_D, OP_TURN_CW, OP_TURN_CCW:
        ph_first = PH_BLEND;
      default: ph_first = PH_TRANS;
    endcase
  end

  always_comb begin
    tv   = (op_r == OP_TURN_CW || op_r == OP_TURN_CCW) ? V_UP : V_DIR;
    ov   = (op_r == OP_TURN_U || op_r == OP_TURN_D) ? V_UP : V_RGT;
    bneg = (op_r == OP_TURN_R || op_r == OP_TURN_U || op_r == OP_TURN_CCW);
    if (op_r == OP_TURN_U || op_r == OP_TURN_D) begin
      cav = V_DIR;
      cbv = V_RGT;
      crv = V_UP;
    end else begin
      cav = V_UP;
      cbv = V_DIR;
      crv = V_RGT;
    end
    if (op_r == OP_FRONT || op_r == OP_BACK) mv = V_DIR;
    else if (op_r == OP_LEFT || op_r == OP_RIGHT) mv = V_RGT;
    else mv = V_UP;
    mneg = (op_r == OP_FRONT || op_r == OP_LEFT || op_r == OP_DOWN);
  end

  always_comb begin
    case (ph_r)
      PH_BLEND: ph_after = PH_CROSS;
      default:  ph_after = PH_TRANS;
    endcase
  end

  always_comb begin
    case (ph_r)
      PH_TRANS: last_t = (t_r == 2'd2);
      PH_MOVE:  last_t = 1'b1;
      default:  last_t = (t_r == 2'd1);
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_pos = accept && (in_opcode == OP_LOAD_POS);
    cmd.load_ori = accept && (in_opcode == OP_LOAD_ORI);
    cmd.mul_en   = (state_r == S_MUL);
    cmd.acc_en   = (state_r == S_ACC);
    cmd.wb_en    = (state_r == S_WB);
    cmd.out_load = (state_r == S_DONE) && (!ov_r || out_tready);
    cmd.first    = (t_r == 2'd0);
    cmd.wb_idx   = i_r;
    cmd.b_idx    = i_r;
    cmd.a_idx    = i_r;
    case (ph_r)
      PH_BLEND: begin
        cmd.a_src   = (t_r == 2'd0) ? A_COS : A_SIN;
        cmd.b_vec   = (t_r == 2'd0) ? tv : ov;
        cmd.neg     = (t_r != 2'd0) && bneg;
        cmd.wb_mode = WB_VEC;
        cmd.wb_vec  = tv;
      end
      PH_CROSS: begin
        cmd.a_src   = A_VEC;
        cmd.a_vec   = cav;
        cmd.a_idx   = (t_r == 2'd0) ? i1 : i2;
        cmd.b_vec   = cbv;
        cmd.b_idx   = (t_r == 2'd0) ? i2 : i1;
        cmd.neg     = (t_r != 2'd0);
        cmd.wb_mode = WB_VEC;
        cmd.wb_vec  = crv;
      end
      PH_MOVE: begin
        cmd.a_src   = A_STEP;
        cmd.b_vec   = mv;
        cmd.wb_mode = mneg ? WB_PSUB : WB_PADD;
      end
      default: begin
        cmd.a_src   = A_POS;
        cmd.a_idx   = t_r;
        cmd.b_idx   = t_r;
        cmd.b_vec   = (i_r == 2'd0) ? V_RGT : ((i_r == 2'd1) ? V_UP : V_DIR);
        cmd.wb_mode = WB_TRANS;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    t_nxt     = t_r;
    ov_nxt    = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          ph_nxt    = ph_first;
          i_nxt     = 2'd0;
          t_nxt     = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (last_t) begin
          state_nxt = S_WB;
        end else begin
          t_nxt     = t_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_WB: begin
        t_nxt = 2'd0;
        if (i_r == 2'd2) begin
          i_nxt = 2'd0;
          if (ph_r == PH_TRANS) begin
            state_nxt = S_DONE;
          end else begin
            ph_nxt    = ph_after;
            state_nxt = S_MUL;
          end
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= '0;
      ph_r    <= PH_TRANS;
      i_r     <= '0;
      t_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      t_r     <= t_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== sv/fcpu_dp.sv =====
// datapath: pose registers, shared multiplier, accumulator, writeback and output register
// depends on fcpu_pkg
module fcpu_dp import fcpu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  fcpu_cmd_t       cmd,
  input  logic [InW-1:0]  in_tdata,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [31:0]     cfg_wdata,
  output logic [OutW-1:0] out_tdata
);

  logic signed [PosW-1:0]  step_r;
  logic signed [15:0]      cos_r, sin_r;
  logic signed [PosW-1:0]  pos_r [0:2];
  logic signed [VecW-1:0]  vec_r [0:2][0:2];
  logic signed [PosW-1:0]  tr_r  [0:2];
  logic signed [ProdW-1:0] p_r;
  logic signed [AccW-1:0]  acc_r;
  logic [OutW-1:0]         out_r;

  logic signed [PosW-1:0]  a_op;
  logic signed [VecW-1:0]  b_op;
  logic signed [AccW-1:0]  addend, base, rsum;
  logic signed [RndW-1:0]  rnd;
  logic signed [39:0]      rnd40, pos40, sum40;

  always_comb begin
    case (cmd.a_src)
      A_STEP:  a_op = step_r;
      A_COS:   a_op = PosW'(cos_r);
      A_SIN:   a_op = PosW'(sin_r);
      A_POS:   a_op = pos_r[cmd.a_idx];
      default: a_op = PosW'(vec_r[cmd.a_vec][cmd.a_idx]);
    endcase
  end
  assign b_op = vec_r[cmd.b_vec][cmd.b_idx];

  assign base   = cmd.first ? '0 : acc_r;
  assign addend = cmd.neg ? -AccW'(p_r) : AccW'(p_r);
  assign rsum   = acc_r + AccW'(8192);
  assign rnd    = rsum[AccW-1:14];
  assign rnd40  = 40'(rnd);
  assign pos40  = 40'(pos_r[cmd.wb_idx]);

  always_comb begin
    case (cmd.wb_mode)
      WB_PADD:  sum40 = pos40 + rnd40;
      WB_PSUB:  sum40 = pos40 - rnd40;
      WB_TRANS: sum40 = -rnd40;
      default:  sum40 = rnd40;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 32'sd6554;
      cos_r  <= 16'sd16382;
      sin_r  <= 16'sd286;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        for (int j = 0; j < 3; j++) vec_r[i][j] <= '0;
      end
      vec_r[V_DIR][2] <= 18'sd16384;
      vec_r[V_UP][1]  <= 18'sd16384;
      vec_r[V_RGT][0] <= 18'sd16384;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_STEP: step_r <= cfg_wdata;
          REG_COS:  cos_r  <= cfg_wdata[15:0];
          REG_SIN:  sin_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.load_pos) begin
        pos_r[0] <= in_tdata[35:4];
        pos_r[1] <= in_tdata[67:36];
        pos_r[2] <= in_tdata[99:68];
      end
      if (cmd.load_ori) begin
        vec_r[V_DIR][0] <= sat18(40'($signed(in_tdata[35:4])));
        vec_r[V_DIR][1] <= sat18(40'($signed(in_tdata[67:36])));
        vec_r[V_DIR][2] <= sat18(40'($signed(in_tdata[99:68])));
        vec_r[V_UP][0]  <= in_tdata[117:100];
        vec_r[V_UP][1]  <= in_tdata[135:118];
        vec_r[V_UP][2]  <= in_tdata[153:136];
      end
      if (cmd.wb_en) begin
        case (cmd.wb_mode)
          WB_VEC:   vec_r[cmd.wb_vec][cmd.wb_idx] <= sat18(sum40);
          WB_TRANS: ;
          default:  pos_r[cmd.wb_idx] <= sat32(sum40);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) p_r <= a_op * b_op;
    if (cmd.acc_en) acc_r <= base + addend;
    if (cmd.wb_en && cmd.wb_mode == WB_TRANS) tr_r[cmd.wb_idx] <= sat32(sum40);
    if (cmd.out_load) begin
      out_r <= {6'd0, tr_r[2], tr_r[1], tr_r[0],
                vec_r[V_DIR][2], vec_r[V_DIR][1], vec_r[V_DIR][0],
                vec_r[V_UP][2], vec_r[V_UP][1], vec_r[V_UP][0],
                vec_r[V_RGT][2], vec_r[V_RGT][1], vec_r[V_RGT][0]};
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== sv/fly_camera_pose_update.sv =====
// camera pose block: one command in, one view matrix out
// from input transfer to out_tvalid, every product passes a multiply step and then an
// accumulate step, one product at a time on one shared multiplier
// a new command is taken only once the last one has loaded its output; the next is taken while the last
// result waits, and it stalls before its own output while that result is still unread
// reset (rst_n low, synchronous): identity orientation, zero position, default registers
// depends on fcpu_pkg, fcpu_ctrl, fcpu_dp
module fly_camera_pose_update import fcpu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // opcode, a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up
  input  logic [InW-1:0]  in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // row0_x..z, row1_x..z, row2_x..z, trans_x, trans_y, trans_z from bit 0 up
  output logic [OutW-1:0] out_tdata,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [31:0]     cfg_wdata
);

  fcpu_cmd_t cmd;

  fcpu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tdata[3:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fcpu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule
